FILE: hdl/pirect_pkg.sv
`default_nettype none

package pirect_pkg;

    // Trig table and fixed-point formats
    localparam int SIN_W      = 15;   // sine magnitude, 0..16384
    localparam int TRIG_W     = 16;   // signed Q1.14 sine/cosine
    localparam int HALF_W     = 15;   // half size register, unsigned Q15.0
    localparam int ONE_SHIFT  = 14;   // multiply by 16384
    localparam int CFG_IDX_W  = 1;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_WIDTH  = 1'b0,
        CFG_HALF_HEIGHT = 1'b1
    } cfg_idx_t;

    // Per-item sign of the folded sine and cosine
    typedef struct packed {
        logic sin_neg;
        logic cos_neg;
    } trig_sign_t;

    // First-quadrant sine in Q1.14, Taylor series in Q2.30, used at elaboration
    function automatic logic [SIN_W-1:0] quad_sine(input longint unsigned r,
                                                   input int angle_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned rnd;
        longint          sum;
        x    = (PI_Q30 * r) >> (angle_bits - 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        // x - x^3/3! + x^5/5! - ... up to x^17, each term built from the last
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        rnd = (longint'(sum) + 64'd32768) >> 16;
        return rnd[SIN_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/point_in_oriented_rect_unit.sv
`default_nettype none

// Channel  Ports                                          Handshake
// -------  ---------------------------------------------  ---------------
// input    s_center_x/y, s_angle, s_test_x/y              s_valid/s_ready
// result   m_inside_res                                   m_valid/m_ready
// config   cfg_index, cfg_wdata                           cfg_wr_en
//
// One transaction per cycle sustained while m_ready is high.
// Pipeline: offset + sine ROM read, four multiplies, two sums, limit compare.
// Each stage has its own valid bit and loads when empty or draining, so bubbles
// collapse and a stalled result never blocks an empty upstream stage.
// aresetn is synchronous, active low; clears valid bits and both half sizes.

module point_in_oriented_rect_unit
    import pirect_pkg::*;
#(
    parameter int ANGLE_BITS = 10,
    parameter int COORD_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // config
    input  wire logic                         cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [HALF_W-1:0]            cfg_wdata,
    // input channel
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [COORD_BITS-1:0] s_center_x,
    input  wire logic signed [COORD_BITS-1:0] s_center_y,
    input  wire logic [ANGLE_BITS-1:0]        s_angle,
    input  wire logic signed [COORD_BITS-1:0] s_test_x,
    input  wire logic signed [COORD_BITS-1:0] s_test_y,
    // result channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_inside_res
);

    localparam int DW      = COORD_BITS + 1;
    localparam int SW      = DW + TRIG_W + 1;
    localparam int IDX_W   = ANGLE_BITS - 1;
    localparam int R_W     = ANGLE_BITS - 2;
    localparam int QUARTER = 1 << R_W;
    localparam int LIM_W   = HALF_W + ONE_SHIFT + 1;
    localparam int CMP_W   = (SW > LIM_W) ? SW : LIM_W;

    logic [HALF_W-1:0]    half_width_reg;
    logic [HALF_W-1:0]    half_height_reg;

    logic                 s1_valid_reg;
    logic                 s1_en;
    logic signed [DW-1:0] dx_reg, dx_next;
    logic signed [DW-1:0] dy_reg, dy_next;
    trig_sign_t           signs_reg, signs_next;
    logic [1:0]           quad_s;
    logic [1:0]           quad_c;
    logic [R_W-1:0]       ang_r;
    logic [IDX_W-1:0]     sin_idx;
    logic [IDX_W-1:0]     cos_idx;
    logic [SIN_W-1:0]     sin_mag;
    logic [SIN_W-1:0]     cos_mag;

    logic                 rot_in_ready;
    logic                 rot_valid;
    logic signed [SW-1:0] rot_u;
    logic signed [SW-1:0] rot_v;

    logic                 out_en;
    logic                 m_valid_reg;
    logic                 inside_reg, inside_next;
    logic signed [CMP_W-1:0] u_ext;
    logic signed [CMP_W-1:0] v_ext;
    logic signed [CMP_W-1:0] lim_u;
    logic signed [CMP_W-1:0] lim_v;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg  <= '0;
            half_height_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_HALF_WIDTH:  half_width_reg  <= cfg_wdata;
                CFG_HALF_HEIGHT: half_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage 1: offsets and quadrant folding for the sine table
    assign s1_en   = !s1_valid_reg || rot_in_ready;
    assign s_ready = s1_en;

    always_comb begin
        dx_next = DW'(s_test_x) - DW'(s_center_x);
        dy_next = DW'(s_test_y) - DW'(s_center_y);
        quad_s  = s_angle[ANGLE_BITS-1 -: 2];
        quad_c  = quad_s + 2'd1;
        ang_r   = s_angle[R_W-1:0];
        sin_idx = quad_s[0] ? IDX_W'(QUARTER) - IDX_W'(ang_r) : IDX_W'(ang_r);
        cos_idx = quad_c[0] ? IDX_W'(QUARTER) - IDX_W'(ang_r) : IDX_W'(ang_r);
        signs_next.sin_neg = quad_s[1];
        signs_next.cos_neg = quad_c[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_en) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_en) begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            signs_reg <= signs_next;
        end
    end

    pirect_sine_rom #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sine_rom (
        .aclk        (aclk),
        .en          (s1_en),
        .sin_idx     (sin_idx),
        .cos_idx     (cos_idx),
        .sin_mag_reg (sin_mag),
        .cos_mag_reg (cos_mag)
    );

    // Stages 2 and 3: rotation into the rectangle frame
    pirect_rotate #(
        .DW (DW),
        .SW (SW)
    ) u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid_reg),
        .in_ready  (rot_in_ready),
        .dx        (dx_reg),
        .dy        (dy_reg),
        .sin_mag   (sin_mag),
        .cos_mag   (cos_mag),
        .signs     (signs_reg),
        .out_valid (rot_valid),
        .out_ready (out_en),
        .u         (rot_u),
        .v         (rot_v)
    );

    // Stage 4: inclusive compare against +/- half size * 16384
    assign out_en = !m_valid_reg || m_ready;

    always_comb begin
        u_ext = CMP_W'(rot_u);
        v_ext = CMP_W'(rot_v);
        lim_u = CMP_W'($signed({1'b0, half_width_reg, ONE_SHIFT'(0)}));
        lim_v = CMP_W'($signed({1'b0, half_height_reg, ONE_SHIFT'(0)}));
        inside_next = (u_ext <= lim_u) && (u_ext >= -lim_u) &&
                      (v_ext <= lim_v) && (v_ext >= -lim_v);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= rot_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            inside_reg <= inside_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = inside_reg;

    // Checks
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    a_ready_only_on_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a blocked result");

    a_accept_enters_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s1_valid_reg)
        else $error("accepted transaction lost at stage 1");

    a_sine_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> ((sin_mag <= SIN_W'(1 << ONE_SHIFT)) &&
                          (cos_mag <= SIN_W'(1 << ONE_SHIFT))))
        else $error("sine table value above one");

endmodule

`default_nettype wire

FILE: hdl/pirect_sine_rom.sv
`default_nettype none

module pirect_sine_rom
    import pirect_pkg::*;
#(
    parameter int ANGLE_BITS = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic [ANGLE_BITS-2:0] sin_idx,
    input  wire logic [ANGLE_BITS-2:0] cos_idx,
    output logic      [SIN_W-1:0]      sin_mag_reg,
    output logic      [SIN_W-1:0]      cos_mag_reg
);

    localparam int QUARTER = 1 << (ANGLE_BITS - 2);

    typedef logic [SIN_W-1:0] sine_tbl_t [0:QUARTER];

    function automatic sine_tbl_t build_sine_tbl();
        sine_tbl_t t;
        for (int r = 0; r <= QUARTER; r++) begin
            t[r] = quad_sine(longint'(r), ANGLE_BITS);
        end
        return t;
    endfunction

    localparam sine_tbl_t SINE_TBL = build_sine_tbl();

    // Two registered read ports, held while the stage is stalled
    always_ff @(posedge aclk) begin
        if (en) begin
            sin_mag_reg <= SINE_TBL[sin_idx];
            cos_mag_reg <= SINE_TBL[cos_idx];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/pirect_rotate.sv
`default_nettype none

module pirect_rotate
    import pirect_pkg::*;
#(
    parameter int DW = 17,
    parameter int SW = DW + TRIG_W + 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [DW-1:0] dx,
    input  wire logic signed [DW-1:0] dy,
    input  wire logic [SIN_W-1:0]     sin_mag,
    input  wire logic [SIN_W-1:0]     cos_mag,
    input  wire trig_sign_t           signs,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [SW-1:0]      u,
    output logic signed [SW-1:0]      v
);

    localparam int PW = DW + TRIG_W;

    logic                 prod_valid_reg;
    logic                 sum_valid_reg;
    logic                 prod_en;
    logic                 sum_en;
    logic signed [TRIG_W-1:0] s_val;
    logic signed [TRIG_W-1:0] c_val;
    logic signed [PW-1:0] xc_reg, xc_next;
    logic signed [PW-1:0] ys_reg, ys_next;
    logic signed [PW-1:0] yc_reg, yc_next;
    logic signed [PW-1:0] xs_reg, xs_next;
    logic signed [SW-1:0] u_reg, u_next;
    logic signed [SW-1:0] v_reg, v_next;

    // Stage enables: a stage loads when it is empty or its content moves on
    assign sum_en   = !sum_valid_reg || out_ready;
    assign prod_en  = !prod_valid_reg || sum_en;
    assign in_ready = prod_en;

    // Signed Q1.14 values from magnitude and quadrant sign
    always_comb begin
        s_val = signs.sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
        c_val = signs.cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
        xc_next = PW'(dx) * PW'(c_val);
        ys_next = PW'(dy) * PW'(s_val);
        yc_next = PW'(dy) * PW'(c_val);
        xs_next = PW'(dx) * PW'(s_val);
    end

    // Product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (prod_en) begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_en) begin
            xc_reg <= xc_next;
            ys_reg <= ys_next;
            yc_reg <= yc_next;
            xs_reg <= xs_next;
        end
    end

    // Sum stage: u = dx*c + dy*s, v = dy*c - dx*s
    assign u_next = SW'(xc_reg) + SW'(ys_reg);
    assign v_next = SW'(yc_reg) - SW'(xs_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (sum_en) begin
            sum_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_en) begin
            u_reg <= u_next;
            v_reg <= v_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign u         = u_reg;
    assign v         = v_reg;

endmodule

`default_nettype wire
